@@ hdl/tdro_pkg.sv @@
// Shared types, codes and constants of the triangle depth raster and occlusion unit.
// Used by the datapath, controller and top level; depends on nothing.
package tdro_pkg;

  localparam int CW = 16;
  localparam int DENW = 36;
  localparam int ZCHUNK = 16;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_DEPTH_BITS = 16;
  localparam int DEF_SUBPIXEL_BITS = 4;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_TRI = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CFG_DW = 9;
  localparam logic [CFG_DW-1:0] RESET_WIDTH = 9'd256;
  localparam logic [7:0] RESET_HEIGHT = 8'd128;

  localparam logic [3:0] OP_IDLE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_BOX = 4'd2;
  localparam logic [3:0] OP_DEN = 4'd3;
  localparam logic [3:0] OP_COEF = 4'd4;
  localparam logic [3:0] OP_EDGE0 = 4'd5;
  localparam logic [3:0] OP_EDGE1 = 4'd6;
  localparam logic [3:0] OP_START = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;
  localparam logic [3:0] OP_READ = 4'd10;
  localparam logic [3:0] OP_WRITE = 4'd11;
  localparam logic [3:0] OP_QCHK = 4'd12;
  localparam logic [3:0] OP_NEXT = 4'd13;
  localparam logic [3:0] OP_CLR = 4'd14;
  localparam logic [3:0] OP_FINISH = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       box_empty;
    logic       den_zero;
    logic       covered;
    logic       last_x;
    logic       last_y;
    logic       mul_last;
    logic       div_done;
    logic       clr_last;
  } stat_t;

endpackage

@@ hdl/tdro_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by tdro_datapath.
module tdro_div #(
  parameter int NUMW = 70,
  parameter int DW = 36,
  parameter int QW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DW-1:0]   den,
  output logic            done,
  output logic [QW-1:0]   quot
);

  localparam int CNTW = $clog2(QW + 1);

  logic [NUMW-1:0] rem;
  logic [NUMW-1:0] dsh;
  logic [CNTW-1:0] cnt;
  logic            fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt <= CNTW'(QW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUMW'(den) << (QW - 1);
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quot <= {quot[QW-2:0], fits};
    end
  end

`ifndef NO_ASSERTIONS
  a_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    start |=> !done) else $error("divider done right after start");
`endif

endmodule

@@ hdl/tdro_datapath.sv @@
// Datapath: input registers, box setup, edge walk, depth interpolation, depth store, query test, clear.
// Depends on tdro_pkg and tdro_div; driven by tdro_ctrl commands.
module tdro_datapath #(
  parameter int MAX_WIDTH = tdro_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tdro_pkg::DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS = tdro_pkg::DEF_DEPTH_BITS,
  parameter int SUBPIXEL_BITS = tdro_pkg::DEF_SUBPIXEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tdro_pkg::cmd_t         cmd,
  output tdro_pkg::stat_t        stat,
  input  logic [143:0]           s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [tdro_pkg::CFG_DW-1:0] cfg_data,
  output logic [1:0]             done_kind,
  output logic                   occluded
);
  import tdro_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(STORE);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PW = $clog2(MAXD) + SUBPIXEL_BITS + 2;
  localparam int DXW = ((PW > 17) ? PW : 17) + 1;
  localparam int PAW = 18 + DXW;
  localparam int EW = PAW + 2;
  localparam int NC = (DEPTH_BITS + ZCHUNK - 1) / ZCHUNK;
  localparam int ZW = NC * ZCHUNK;
  localparam int NUMW = DENW + ZW + 2;
  localparam int PRW = DENW + ZCHUNK;
  localparam int CKW = $clog2(NC + 1);
  localparam int DB = DEPTH_BITS;
  localparam logic [DB-1:0] FAR = '1;

  function automatic logic signed [17:0] dbl(input logic signed [15:0] v);
    return {v[15], v, 1'b0};
  endfunction

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic [CFG_DW-1:0] width_reg;
  logic [7:0]        height_reg;
  logic [1:0]        kind;
  logic signed [15:0] x0, y0, x1, y1, x2, y2;
  logic [DB-1:0]     z0, z1, z2;
  logic signed [17:0] bx0, bx1, by0, by1;
  logic              box_empty;
  logic signed [17:0] ca0, cb0, ca1, cb1, dy0;
  logic signed [DENW:0] den;
  logic [DENW-1:0]   den_abs;
  logic signed [EW-1:0] e0row, e1row, e0, e1;
  logic [XW-1:0]     px;
  logic [YW-1:0]     py;
  logic [AW-1:0]     row_base;
  logic [AW-1:0]     clr_addr;
  logic [NUMW-1:0]   acc;
  logic [1:0]        vsel;
  logic [CKW-1:0]    chunk;
  logic [ZW-1:0]     zs0, zs1, zs2;
  logic [DB-1:0]     rdata;
  logic              fail;
  logic [DB-1:0]     mem [STORE];

  logic [11:0] wq, hq, aw12, ah12;
  logic [WW-1:0] aw;
  logic signed [17:0] wm1, hm1;

  always_comb begin
    wq = 12'(width_reg);
    hq = 12'(height_reg);
    aw12 = (wq < 12'd16) ? 12'd16 : ((wq > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : wq);
    ah12 = (hq < 12'd16) ? 12'd16 : ((hq > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : hq);
    aw = WW'(aw12);
    wm1 = $signed(18'(aw12)) - 18'sd1;
    hm1 = $signed(18'(ah12)) - 18'sd1;
  end

  // bounding box
  logic signed [17:0] mnx, mxx, mny, mxy, lox, hix, loy, hiy, clox, chix, cloy, chiy;
  localparam logic signed [17:0] CEIL_ADD = 18'((1 << SUBPIXEL_BITS) - 1);

  always_comb begin
    mnx = 18'(min3(x0, x1, x2));
    mxx = 18'(max3(x0, x1, x2));
    mny = 18'(min3(y0, y1, y2));
    mxy = 18'(max3(y0, y1, y2));
    if (kind == KIND_QUERY) begin
      lox = 18'(x0);
      loy = 18'(y0);
      hix = 18'(x1);
      hiy = 18'(y1);
    end else begin
      lox = mnx >>> SUBPIXEL_BITS;
      loy = mny >>> SUBPIXEL_BITS;
      hix = (mxx + CEIL_ADD) >>> SUBPIXEL_BITS;
      hiy = (mxy + CEIL_ADD) >>> SUBPIXEL_BITS;
    end
    clox = (lox < 18'sd0) ? 18'sd0 : lox;
    cloy = (loy < 18'sd0) ? 18'sd0 : loy;
    chix = (hix > wm1) ? wm1 : hix;
    chiy = (hiy > hm1) ? hm1 : hiy;
  end

  // setup products
  logic signed [35:0] dp0, dp1;
  logic signed [DXW-1:0] px0s, py0s, x2d, y2d, ddx, ddy;
  logic signed [17:0] ma, mb;
  logic signed [PAW-1:0] pa, pb;
  logic [DXW-1:0] px0u, py0u;

  assign dp0 = 36'(ca0) * 36'(cb1);
  assign dp1 = 36'(cb0) * 36'(dy0);
  assign px0u = (DXW'(bx0[XW-1:0]) << (SUBPIXEL_BITS + 1)) | (DXW'(1) << SUBPIXEL_BITS);
  assign py0u = (DXW'(by0[YW-1:0]) << (SUBPIXEL_BITS + 1)) | (DXW'(1) << SUBPIXEL_BITS);
  assign px0s = $signed(px0u);
  assign py0s = $signed(py0u);
  assign x2d = DXW'(dbl(x2));
  assign y2d = DXW'(dbl(y2));
  assign ddx = px0s - x2d;
  assign ddy = py0s - y2d;
  assign ma = (cmd.op == OP_EDGE0) ? ca0 : ca1;
  assign mb = (cmd.op == OP_EDGE0) ? cb0 : cb1;
  assign pa = PAW'(ma) * PAW'(ddx);
  assign pb = PAW'(mb) * PAW'(ddy);

  logic signed [EW-1:0] sx0, sx1, sy0, sy1;
  assign sx0 = EW'(ca0) <<< (SUBPIXEL_BITS + 1);
  assign sx1 = EW'(ca1) <<< (SUBPIXEL_BITS + 1);
  assign sy0 = EW'(cb0) <<< (SUBPIXEL_BITS + 1);
  assign sy1 = EW'(cb1) <<< (SUBPIXEL_BITS + 1);

  // pixel test and interpolation
  logic signed [EW+1:0] e2;
  logic [DENW-1:0] ev;
  logic [ZCHUNK-1:0] zv;
  logic [PRW-1:0] prod;
  logic [DB-1:0] quot;
  logic div_done;
  logic [AW-1:0] addr;
  logic last_x, last_y;

  assign e2 = (EW + 2)'($signed({1'b0, den_abs})) - (EW + 2)'(e0) - (EW + 2)'(e1);
  always_comb begin
    case (vsel)
      2'd0: ev = e0[DENW-1:0];
      2'd1: ev = e1[DENW-1:0];
      default: ev = e2[DENW-1:0];
    endcase
    case (vsel)
      2'd0: zv = zs0[ZW-1 -: ZCHUNK];
      2'd1: zv = zs1[ZW-1 -: ZCHUNK];
      default: zv = zs2[ZW-1 -: ZCHUNK];
    endcase
  end
  assign prod = PRW'(ev) * PRW'(zv);
  assign addr = row_base + AW'(px);
  assign last_x = px == bx1[XW-1:0];
  assign last_y = py == by1[YW-1:0];

  tdro_div #(.NUMW(NUMW), .DW(DENW), .QW(DB)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == OP_DIV),
    .num  (acc),
    .den  (den_abs),
    .done (div_done),
    .quot (quot)
  );

  assign stat.kind = kind;
  assign stat.box_empty = box_empty;
  assign stat.den_zero = den == '0;
  assign stat.covered = !e0[EW-1] && !e1[EW-1] && !e2[EW+1];
  assign stat.last_x = last_x;
  assign stat.last_y = last_y;
  assign stat.mul_last = (vsel == 2'd2) && (chunk == CKW'(NC - 1));
  assign stat.div_done = div_done;
  assign stat.clr_last = clr_addr == AW'(STORE - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
      clr_addr <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg <= cfg_data;
        end else begin
          height_reg <= cfg_data[7:0];
        end
      end
      if (cmd.op == OP_CLR) begin
        clr_addr <= stat.clr_last ? '0 : clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind <= s_tuser;
        x0 <= s_tdata[15:0];
        y0 <= s_tdata[31:16];
        z0 <= DB'(s_tdata[47:32]);
        x1 <= s_tdata[63:48];
        y1 <= s_tdata[79:64];
        z1 <= DB'(s_tdata[95:80]);
        x2 <= s_tdata[111:96];
        y2 <= s_tdata[127:112];
        z2 <= DB'(s_tdata[143:128]);
        fail <= 1'b0;
      end
      OP_BOX: begin
        bx0 <= clox;
        bx1 <= chix;
        by0 <= cloy;
        by1 <= chiy;
        box_empty <= (clox > chix) || (cloy > chiy);
        ca0 <= dbl(y1) - dbl(y2);
        cb0 <= dbl(x2) - dbl(x1);
        ca1 <= dbl(y2) - dbl(y0);
        cb1 <= dbl(x0) - dbl(x2);
        dy0 <= dbl(y0) - dbl(y2);
      end
      OP_DEN: begin
        den <= (DENW + 1)'(dp0) + (DENW + 1)'(dp1);
      end
      OP_COEF: begin
        den_abs <= den[DENW] ? DENW'(-den) : DENW'(den);
        if (den[DENW]) begin
          ca0 <= -ca0;
          cb0 <= -cb0;
          ca1 <= -ca1;
          cb1 <= -cb1;
        end
      end
      OP_EDGE0: e0row <= EW'(pa) + EW'(pb);
      OP_EDGE1: e1row <= EW'(pa) + EW'(pb);
      OP_START: begin
        px <= bx0[XW-1:0];
        py <= by0[YW-1:0];
        e0 <= e0row;
        e1 <= e1row;
        row_base <= AW'(by0[YW-1:0]) * AW'(aw);
        acc <= '0;
        vsel <= 2'd0;
        chunk <= '0;
        zs0 <= ZW'(z0);
        zs1 <= ZW'(z1);
        zs2 <= ZW'(z2);
      end
      OP_MUL: begin
        if (vsel == 2'd0) begin
          acc <= (acc << ZCHUNK) + NUMW'(prod);
        end else begin
          acc <= acc + NUMW'(prod);
        end
        if (vsel == 2'd2) begin
          vsel <= 2'd0;
          chunk <= chunk + 1'b1;
          zs0 <= zs0 << ZCHUNK;
          zs1 <= zs1 << ZCHUNK;
          zs2 <= zs2 << ZCHUNK;
        end else begin
          vsel <= vsel + 2'd1;
        end
      end
      OP_QCHK: begin
        if (rdata >= z0) begin
          fail <= 1'b1;
        end
      end
      OP_NEXT: begin
        acc <= '0;
        vsel <= 2'd0;
        chunk <= '0;
        zs0 <= ZW'(z0);
        zs1 <= ZW'(z1);
        zs2 <= ZW'(z2);
        if (!last_x) begin
          px <= px + 1'b1;
          e0 <= e0 + sx0;
          e1 <= e1 + sx1;
        end else begin
          px <= bx0[XW-1:0];
          py <= py + 1'b1;
          e0row <= e0row + sy0;
          e1row <= e1row + sy1;
          e0 <= e0row + sy0;
          e1 <= e1row + sy1;
          row_base <= row_base + AW'(aw);
        end
      end
      OP_FINISH: begin
        done_kind <= kind;
        occluded <= (kind == KIND_QUERY) && !box_empty && !fail;
      end
      default: ;
    endcase
  end

  logic          we;
  logic [AW-1:0] waddr;
  logic [DB-1:0] wdata;

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = quot;
    if (cmd.op == OP_CLR) begin
      we = 1'b1;
      waddr = clr_addr;
      wdata = FAR;
    end else if (cmd.op == OP_WRITE) begin
      we = quot < rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.op == OP_READ) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/tdro_ctrl.sv @@
// Controller state machine: sequences setup, pixel walk, clearing and result hand-off.
// Depends on tdro_pkg; drives tdro_datapath through cmd_t and reads stat_t.
module tdro_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output tdro_pkg::cmd_t  cmd,
  input  tdro_pkg::stat_t stat
);
  import tdro_pkg::*;

  localparam logic [4:0] ST_RCLR = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_BOX = 5'd2;
  localparam logic [4:0] ST_DEN = 5'd3;
  localparam logic [4:0] ST_COEF = 5'd4;
  localparam logic [4:0] ST_EDGE0 = 5'd5;
  localparam logic [4:0] ST_EDGE1 = 5'd6;
  localparam logic [4:0] ST_START = 5'd7;
  localparam logic [4:0] ST_PIX = 5'd8;
  localparam logic [4:0] ST_MUL = 5'd9;
  localparam logic [4:0] ST_DIVS = 5'd10;
  localparam logic [4:0] ST_DIVW = 5'd11;
  localparam logic [4:0] ST_READ = 5'd12;
  localparam logic [4:0] ST_WRITE = 5'd13;
  localparam logic [4:0] ST_QREAD = 5'd14;
  localparam logic [4:0] ST_QCHK = 5'd15;
  localparam logic [4:0] ST_NEXT = 5'd16;
  localparam logic [4:0] ST_CLR = 5'd17;
  localparam logic [4:0] ST_FIN = 5'd18;

  logic [4:0] state, state_next;
  logic       out_free;
  logic       is_tri;

  assign out_free = !m_tvalid || m_tready;
  assign is_tri = stat.kind == KIND_TRI;
  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.op = OP_IDLE;
    unique case (state)
      ST_RCLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          state_next = ST_BOX;
        end
      end
      ST_BOX: begin
        cmd.op = OP_BOX;
        case (stat.kind)
          KIND_CLEAR: state_next = ST_CLR;
          KIND_TRI, KIND_QUERY: state_next = ST_DEN;
          default: state_next = ST_FIN;
        endcase
      end
      ST_DEN: begin
        cmd.op = OP_DEN;
        if (stat.box_empty) state_next = ST_FIN;
        else if (is_tri) state_next = ST_COEF;
        else state_next = ST_START;
      end
      ST_COEF: begin
        cmd.op = OP_COEF;
        state_next = stat.den_zero ? ST_FIN : ST_EDGE0;
      end
      ST_EDGE0: begin
        cmd.op = OP_EDGE0;
        state_next = ST_EDGE1;
      end
      ST_EDGE1: begin
        cmd.op = OP_EDGE1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.op = OP_START;
        state_next = is_tri ? ST_PIX : ST_QREAD;
      end
      ST_PIX: state_next = stat.covered ? ST_MUL : ST_NEXT;
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (stat.mul_last) state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.op = OP_DIV;
        state_next = ST_DIVW;
      end
      ST_DIVW: if (stat.div_done) state_next = ST_READ;
      ST_READ: begin
        cmd.op = OP_READ;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.op = OP_WRITE;
        state_next = ST_NEXT;
      end
      ST_QREAD: begin
        cmd.op = OP_READ;
        state_next = ST_QCHK;
      end
      ST_QCHK: begin
        cmd.op = OP_QCHK;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.op = OP_NEXT;
        if (stat.last_x && stat.last_y) state_next = ST_FIN;
        else state_next = is_tri ? ST_PIX : ST_QREAD;
      end
      ST_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.op = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RCLR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_BOX)) else $error("accepted word not started");
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> ($past(state) == ST_READ)) else $error("write without read");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RCLR) |-> !s_tready) else $error("accept during reset clear");
`endif

endmodule

@@ hdl/triangle_depth_raster_occlusion_unit.sv @@
// Top level of the triangle depth raster and occlusion unit.
// Depends on tdro_pkg, tdro_ctrl and tdro_datapath.
//
//  channel  | signals                        | content
//  s        | s_tvalid s_tready s_tdata/user | one item: kind plus three vertices
//  m        | m_tvalid m_tready m_tdata/user | one result: kind and occluded flag
//  cfg      | cfg_we cfg_index cfg_data      | active width, active height
//
// Clear: writes the far depth to the whole store, one store entry per cycle.
// Triangle: box, denominator, coefficient and edge setup, then per box pixel an
// inside test; a covered pixel is interpolated (serial divider), read and written if nearer.
// Query: one store read and depth check per pixel of the clamped rectangle.
// After reset a clearing pass over the whole store holds s_tready low.
// A result waits in the output register; the next word is taken meanwhile.
module triangle_depth_raster_occlusion_unit #(
  parameter int MAX_WIDTH = tdro_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tdro_pkg::DEF_MAX_HEIGHT,
  parameter int DEPTH_BITS = tdro_pkg::DEF_DEPTH_BITS,
  parameter int SUBPIXEL_BITS = tdro_pkg::DEF_SUBPIXEL_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic [1:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,  // occluded, zero fill
  output logic [1:0]   m_tuser,  // done_kind
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [tdro_pkg::CFG_DW-1:0] cfg_data
);
  import tdro_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  occluded;

  tdro_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  tdro_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .DEPTH_BITS   (DEPTH_BITS),
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done_kind(m_tuser),
    .occluded (occluded)
  );

  assign m_tdata = {7'd0, occluded};

endmodule
